### design/ppmhp_pkg.sv
package ppmhp_pkg;

  // Largest accepted image dimension
  localparam logic [30:0] MaxDim = 31'd65535;
  // Required max value
  localparam logic [30:0] MaxVal = 31'd255;
  // Largest token value, 2^31-1
  localparam logic [34:0] NumLimit = 35'h0_7FFF_FFFF;

  localparam logic [7:0] ChP    = 8'h50;  // 'P'
  localparam logic [7:0] Ch6    = 8'h36;  // '6'
  localparam logic [7:0] ChHash = 8'h23;  // '#'
  localparam logic [7:0] ChLf   = 8'h0A;  // newline

  typedef enum logic [3:0] {
    ST_OK       = 4'd0,
    ST_NOT_P6   = 4'd1,
    ST_HDR_END  = 4'd2,
    ST_BAD_W    = 4'd3,
    ST_BAD_H    = 4'd4,
    ST_BAD_MAX  = 4'd5,
    ST_MAX_N255 = 4'd6,
    ST_NO_SEP   = 4'd7,
    ST_TOO_BIG  = 4'd8,
    ST_SIZE     = 4'd9
  } status_e;

  typedef enum logic [4:0] {
    PH_MAGIC  = 5'b00001,
    PH_WIDTH  = 5'b00010,
    PH_HEIGHT = 5'b00100,
    PH_MAXVAL = 5'b01000,
    PH_RASTER = 5'b10000
  } phase_e;

  // One result item
  typedef struct packed {
    logic        pix_valid;
    logic [7:0]  pix_byte;
    logic        done_res;
    status_e     status;
    logic [15:0] img_width;
    logic [15:0] img_height;
  } res_t;

endpackage

### design/ppmhp_in_reg.sv
module ppmhp_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  input  logic       adv_i,
  output logic       vld_o,
  output logic [7:0] byte_o,
  output logic       last_o
);
  logic       vld_q;
  logic [7:0] byte_q;
  logic       last_q;

  // held item waits only while the result side cannot move
  assign in_stall_o = vld_q & ~adv_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      byte_q <= in_byte_i;
      last_q <= in_last_i;
    end
  end

  assign vld_o  = vld_q;
  assign byte_o = byte_q;
  assign last_o = last_q;
endmodule

### design/ppmhp_parse.sv
module ppmhp_parse (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  logic [7:0]     byte_i,
  input  logic           last_i,
  output ppmhp_pkg::res_t res_o
);
  import ppmhp_pkg::*;

  phase_e      phase_q, phase_d;
  logic        comment_q, comment_d;
  logic        token_q, token_d;
  logic [1:0]  pos_q, pos_d;
  logic        magic_q, magic_d;
  logic [30:0] acc_q, acc_d;
  logic        bad_q, bad_d;
  logic        large_q, large_d;
  logic [15:0] width_q, width_d;
  logic [15:0] height_q, height_d;
  logic [1:0]  ch_q, ch_d;
  logic [15:0] col_q, col_d;
  logic [15:0] row_q, row_d;
  logic        rdone_q, rdone_d;
  status_e     err_q, err_d;

  logic        is_space, is_digit;
  logic        feed_en, judge_en, term;
  logic        num_ok, pv;
  logic [34:0] nv;

  assign is_space = byte_i inside {8'h20, 8'h09, 8'h0A, 8'h0D, 8'h0B, 8'h0C};
  assign is_digit = byte_i inside {[8'h30:8'h39]};
  // acc*10 + digit
  assign nv = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + {31'b0, byte_i[3:0]};

  always_comb begin
    phase_d   = phase_q;
    comment_d = comment_q;
    token_d   = token_q;
    pos_d     = pos_q;
    magic_d   = magic_q;
    acc_d     = acc_q;
    bad_d     = bad_q;
    large_d   = large_q;
    width_d   = width_q;
    height_d  = height_q;
    ch_d      = ch_q;
    col_d     = col_q;
    row_d     = row_q;
    rdone_d   = rdone_q;
    err_d     = err_q;
    feed_en   = 1'b0;
    judge_en  = 1'b0;
    term      = 1'b0;
    num_ok    = 1'b0;
    pv        = 1'b0;

    // byte dispatch
    if (err_q == ST_OK) begin
      if (phase_q == PH_RASTER) begin
        if (!rdone_q) begin
          pv = 1'b1;
          if (ch_q == 2'd2) begin
            ch_d = 2'd0;
            if (col_q == width_q - 16'd1) begin
              col_d = 16'd0;
              if (row_q == height_q - 16'd1) begin
                rdone_d = 1'b1;
              end else begin
                row_d = row_q + 16'd1;
              end
            end else begin
              col_d = col_q + 16'd1;
            end
          end else begin
            ch_d = ch_q + 2'd1;
          end
        end else begin
          err_d = ST_SIZE;
        end
      end else if (comment_q) begin
        if (byte_i == ChLf) begin
          comment_d = 1'b0;
        end
      end else if (!token_q) begin
        if (is_space) begin
          comment_d = comment_q;
        end else if (byte_i == ChHash) begin
          comment_d = 1'b1;
        end else begin
          token_d = 1'b1;
          feed_en = 1'b1;
        end
      end else if (is_space) begin
        judge_en = 1'b1;
        term     = 1'b1;
      end else begin
        feed_en = 1'b1;
      end
    end

    // token character
    if (feed_en) begin
      if (phase_q == PH_MAGIC) begin
        if (pos_q == 2'd0 && byte_i != ChP) begin
          magic_d = 1'b0;
        end else if (pos_q == 2'd1 && byte_i != Ch6) begin
          magic_d = 1'b0;
        end else if (pos_q[1]) begin
          magic_d = 1'b0;
        end
        if (pos_q != 2'd3) begin
          pos_d = pos_q + 2'd1;
        end
      end else if (!bad_q) begin
        if (!is_digit || nv > NumLimit) begin
          bad_d = 1'b1;
        end else begin
          acc_d = nv[30:0];
        end
      end
    end

    // open token at end of file is judged unterminated
    if (last_i && err_q == ST_OK && token_d && phase_q != PH_RASTER && !judge_en) begin
      judge_en = 1'b1;
    end

    if (judge_en) begin
      num_ok = !bad_d && acc_d != 31'd0;
      case (phase_q)
        PH_MAGIC: begin
          if (magic_d && pos_d == 2'd2) phase_d = PH_WIDTH;
          else err_d = ST_NOT_P6;
        end
        PH_WIDTH: begin
          if (!num_ok) begin
            err_d = ST_BAD_W;
          end else begin
            width_d = (acc_d > 31'd65535) ? 16'hFFFF : acc_d[15:0];
            if (acc_d > MaxDim) large_d = 1'b1;
            phase_d = PH_HEIGHT;
          end
        end
        PH_HEIGHT: begin
          if (!num_ok) begin
            err_d = ST_BAD_H;
          end else begin
            height_d = (acc_d > 31'd65535) ? 16'hFFFF : acc_d[15:0];
            if (acc_d > MaxDim) large_d = 1'b1;
            phase_d = PH_MAXVAL;
          end
        end
        PH_MAXVAL: begin
          if (!num_ok) err_d = ST_BAD_MAX;
          else if (acc_d != MaxVal) err_d = ST_MAX_N255;
          else if (!term) err_d = ST_NO_SEP;
          else if (large_q) err_d = ST_TOO_BIG;
          else begin
            phase_d = PH_RASTER;
            ch_d    = 2'd0;
            col_d   = 16'd0;
            row_d   = 16'd0;
            rdone_d = 1'b0;
          end
        end
        default: begin
          err_d = err_q;
        end
      endcase
      token_d = 1'b0;
      pos_d   = 2'd0;
      magic_d = 1'b1;
      acc_d   = 31'd0;
      bad_d   = 1'b0;
    end

    // final status
    if (last_i && err_d == ST_OK) begin
      if (phase_d != PH_RASTER) err_d = ST_HDR_END;
      else if (!rdone_d) err_d = ST_SIZE;
    end

    res_o.pix_valid  = pv;
    res_o.pix_byte   = pv ? byte_i : 8'h00;
    res_o.done_res   = last_i;
    res_o.status     = err_d;
    res_o.img_width  = width_d;
    res_o.img_height = height_d;

    // end of file: back to reset state
    if (last_i) begin
      phase_d   = PH_MAGIC;
      comment_d = 1'b0;
      token_d   = 1'b0;
      pos_d     = 2'd0;
      magic_d   = 1'b1;
      acc_d     = 31'd0;
      bad_d     = 1'b0;
      large_d   = 1'b0;
      width_d   = 16'd0;
      height_d  = 16'd0;
      rdone_d   = 1'b0;
      err_d     = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_MAGIC;
      comment_q <= 1'b0;
      token_q   <= 1'b0;
      pos_q     <= 2'd0;
      magic_q   <= 1'b1;
      acc_q     <= 31'd0;
      bad_q     <= 1'b0;
      large_q   <= 1'b0;
      width_q   <= 16'd0;
      height_q  <= 16'd0;
      ch_q      <= 2'd0;
      col_q     <= 16'd0;
      row_q     <= 16'd0;
      rdone_q   <= 1'b0;
      err_q     <= ST_OK;
    end else if (step_i) begin
      phase_q   <= phase_d;
      comment_q <= comment_d;
      token_q   <= token_d;
      pos_q     <= pos_d;
      magic_q   <= magic_d;
      acc_q     <= acc_d;
      bad_q     <= bad_d;
      large_q   <= large_d;
      width_q   <= width_d;
      height_q  <= height_d;
      ch_q      <= ch_d;
      col_q     <= col_d;
      row_q     <= row_d;
      rdone_q   <= rdone_d;
      err_q     <= err_d;
    end
  end
endmodule

### design/ppmhp_out_reg.sv
module ppmhp_out_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            vld_i,
  input  ppmhp_pkg::res_t res_i,
  output logic            adv_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output ppmhp_pkg::res_t res_o
);
  import ppmhp_pkg::*;

  logic vld_q;
  res_t res_q;

  // register free or being emptied this cycle
  assign adv_o = ~vld_q | ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_o) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && vld_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = vld_q;
  assign res_o       = res_q;
endmodule

### design/ppm_p6_header_parser_top.sv
// PPM P6 header parser with raster pass-through.
// Input channel: one file byte per item (in_byte_i) with in_last_i marking
// the final byte. Output channel: exactly one result item per input item.
// Header bytes come out with pix_valid_o low; raster bytes come out with
// pix_valid_o high and the byte on pix_byte_o. status_o carries the sticky
// error code so far and is final on the item with done_res_o set.
// img_width_o / img_height_o show the parsed dimensions, zero until known.
// Path: an accepted item goes through the input register, then the parse
// logic into the result register.
// Throughput: one item per cycle unless stalled; the parse state is a handful
// of flops updated by one small step per byte (a x10 shift-add for numbers
// and the raster channel/column/row counters).
// Stalls: while out_stall_i holds a waiting result, the input register
// keeps one more item and in_stall_o rises only if that register is full.
// Reset: rst_ni clears both registers and returns the parser to the
// start-of-file state; the last byte of each file does the same.
module ppm_p6_header_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        in_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        pix_valid_o,
  output logic [7:0]  pix_byte_o,
  output logic        done_res_o,
  output logic [3:0]  status_o,
  output logic [15:0] img_width_o,
  output logic [15:0] img_height_o
);
  import ppmhp_pkg::*;

  logic       adv;
  logic       in_vld;
  logic [7:0] in_byte;
  logic       in_last;
  res_t       step_res;
  res_t       out_res;

  ppmhp_in_reg u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .adv_i      (adv),
    .vld_o      (in_vld),
    .byte_o     (in_byte),
    .last_o     (in_last)
  );

  // state advances only when the item moves into the result register
  ppmhp_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (in_vld & adv),
    .byte_i (in_byte),
    .last_i (in_last),
    .res_o  (step_res)
  );

  ppmhp_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vld_i       (in_vld),
    .res_i       (step_res),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (out_res)
  );

  assign pix_valid_o  = out_res.pix_valid;
  assign pix_byte_o   = out_res.pix_byte;
  assign done_res_o   = out_res.done_res;
  assign status_o     = out_res.status;
  assign img_width_o  = out_res.img_width;
  assign img_height_o = out_res.img_height;
endmodule

### design/ppmhp_chk.sv
module ppmhp_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        pix_valid_o,
  input logic [7:0]  pix_byte_o,
  input logic        done_res_o,
  input logic [3:0]  status_o,
  input logic [15:0] img_width_o,
  input logic [15:0] img_height_o
);

  // a held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
    $stable(pix_byte_o) && $stable(done_res_o))
    else $error("result changed while stalled");

  // input side only backs up behind a stalled full result register
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // raster items only with known, nonzero dimensions
  a_pix_dims: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pix_valid_o |-> img_width_o != 16'd0 && img_height_o != 16'd0)
    else $error("raster item without dimensions");

  // header items carry a zero byte
  a_pix_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !pix_valid_o |-> pix_byte_o == 8'd0)
    else $error("nonzero byte on header item");

  // the item after end of file starts a fresh header
  a_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o && !out_stall_i |=>
    !out_valid_o || (img_width_o == 16'd0 && img_height_o == 16'd0))
    else $error("dimensions survived end of file");

endmodule

bind ppm_p6_header_parser_top ppmhp_chk u_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .pix_valid_o  (pix_valid_o),
  .pix_byte_o   (pix_byte_o),
  .done_res_o   (done_res_o),
  .status_o     (status_o),
  .img_width_o  (img_width_o),
  .img_height_o (img_height_o)
);

### sim/ppm_p6_header_parser_top_test.sv
// Self-checking bench for the PPM P6 header parser.
// Whole files are streamed in one byte per item. Every accepted byte is run
// through a behavioral parser kept in this module, and the result it gives is
// queued. The output side pops the queue on each accepted result and compares
// all fields.
module ppm_p6_header_parser_top_test;
  import ppmhp_pkg::*;

  localparam int unsigned CycleLimit = 400000;  // far above the slowest run
  localparam int unsigned HoldCycles = 300;     // long output hold-off
  localparam int unsigned RandItems  = 1600;
  localparam int unsigned MaxPrints  = 50;      // keeps the log short
  localparam logic [7:0]  ChZero     = 8'h30;
  localparam logic [7:0]  ChNine     = 8'h39;

  logic        clk_i;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_stall_o;
  logic [7:0]  in_byte_i    = 8'h00;
  logic        in_last_i    = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i  = 1'b0;
  logic        pix_valid_o;
  logic [7:0]  pix_byte_o;
  logic        done_res_o;
  logic [3:0]  status_o;
  logic [15:0] img_width_o;
  logic [15:0] img_height_o;

  // Bench control
  int unsigned cycle_cnt     = 0;
  int unsigned bad_cnt       = 0;
  int unsigned live_items    = 0;  // bytes that the parser did not ignore
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        hold_on       = 1'b0;
  event        hold_ev;

  logic [7:0] file_q[$];       // file being assembled
  res_t       parse_res_q[$];  // parse results waiting for the output side

  // Behavioral parser state
  phase_e      hdr_phase;
  logic        hdr_in_cmt;
  logic        hdr_in_tok;
  logic [1:0]  tok_len;      // saturates at 3
  logic        tok_is_p6;
  logic [31:0] tok_val;
  logic        tok_bad;
  logic        dim_over;     // a dimension went above MaxDim
  logic [15:0] exp_width;
  logic [15:0] exp_height;
  logic [33:0] bytes_left;   // raster bytes still owed
  status_e     sticky_st;

  ppm_p6_header_parser_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_byte_i   (in_byte_i),
    .in_last_i   (in_last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pix_valid_o (pix_valid_o),
    .pix_byte_o  (pix_byte_o),
    .done_res_o  (done_res_o),
    .status_o    (status_o),
    .img_width_o (img_width_o),
    .img_height_o(img_height_o)
  );

  // ---------------------------------------------------------------------------
  // Behavioral parser
  // ---------------------------------------------------------------------------

  function automatic logic is_ws(input logic [7:0] c);
    return c inside {8'h20, 8'h09, 8'h0A, 8'h0D, 8'h0B, 8'h0C};
  endfunction

  task automatic clear_tok();
    hdr_in_tok = 1'b0;
    tok_len    = 2'd0;
    tok_is_p6  = 1'b1;
    tok_val    = 32'd0;
    tok_bad    = 1'b0;
  endtask

  // State at reset and after the last byte of every file
  task automatic start_file();
    hdr_phase  = PH_MAGIC;
    hdr_in_cmt = 1'b0;
    clear_tok();
    dim_over   = 1'b0;
    exp_width  = 16'd0;
    exp_height = 16'd0;
    bytes_left = 34'd0;
    sticky_st  = ST_OK;
  endtask

  // One byte of an open token
  task automatic tok_take(input logic [7:0] c);
    logic [35:0] acc;
    if (hdr_phase == PH_MAGIC) begin
      if (tok_len == 2'd0 && c != ChP) tok_is_p6 = 1'b0;
      else if (tok_len == 2'd1 && c != Ch6) tok_is_p6 = 1'b0;
      else if (tok_len >= 2'd2) tok_is_p6 = 1'b0;
      if (tok_len != 2'd3) tok_len = tok_len + 2'd1;
    end else if (!tok_bad) begin
      if (c < ChZero || c > ChNine) begin
        tok_bad = 1'b1;  // signs and letters alike
      end else begin
        acc = {4'd0, tok_val} * 36'd10 + {28'd0, c - ChZero};
        if (acc > {1'b0, NumLimit}) tok_bad = 1'b1;
        else tok_val = acc[31:0];
      end
    end
  endtask

  // Judge a finished token; ended is low when end of file closed it
  task automatic tok_close(input logic ended);
    logic num_ok;
    num_ok = !tok_bad && tok_val != 32'd0;
    case (hdr_phase)
      PH_MAGIC: begin
        if (tok_is_p6 && tok_len == 2'd2) hdr_phase = PH_WIDTH;
        else sticky_st = ST_NOT_P6;
      end
      PH_WIDTH: begin
        if (!num_ok) begin
          sticky_st = ST_BAD_W;
        end else begin
          exp_width = (tok_val > 32'd65535) ? 16'hFFFF : tok_val[15:0];
          if (tok_val > {1'b0, MaxDim}) dim_over = 1'b1;
          hdr_phase = PH_HEIGHT;
        end
      end
      PH_HEIGHT: begin
        if (!num_ok) begin
          sticky_st = ST_BAD_H;
        end else begin
          exp_height = (tok_val > 32'd65535) ? 16'hFFFF : tok_val[15:0];
          if (tok_val > {1'b0, MaxDim}) dim_over = 1'b1;
          hdr_phase = PH_MAXVAL;
        end
      end
      default: begin
        // Too large is only raised once the separator is in
        if (!num_ok) sticky_st = ST_BAD_MAX;
        else if (tok_val != {1'b0, MaxVal}) sticky_st = ST_MAX_N255;
        else if (!ended) sticky_st = ST_NO_SEP;
        else if (dim_over) sticky_st = ST_TOO_BIG;
        else begin
          bytes_left = {18'd0, exp_width} * {18'd0, exp_height} * 34'd3;
          hdr_phase  = PH_RASTER;
        end
      end
    endcase
    clear_tok();
  endtask

  // Expected result for one accepted byte
  task automatic parse_byte(input logic [7:0] c, input logic last, output res_t r);
    r.pix_valid = 1'b0;
    r.pix_byte  = 8'h00;
    if (sticky_st == ST_OK) begin
      if (hdr_phase == PH_RASTER) begin
        if (bytes_left != 34'd0) begin
          r.pix_valid = 1'b1;
          r.pix_byte  = c;
          bytes_left  = bytes_left - 34'd1;
        end else begin
          sticky_st = ST_SIZE;  // first excess byte is dropped
        end
      end else if (hdr_in_cmt) begin
        if (c == ChLf) hdr_in_cmt = 1'b0;
      end else if (!hdr_in_tok) begin
        if (!is_ws(c)) begin
          if (c == ChHash) begin
            hdr_in_cmt = 1'b1;
          end else begin
            hdr_in_tok = 1'b1;
            tok_take(c);
          end
        end
      end else if (is_ws(c)) begin
        tok_close(1'b1);
      end else begin
        tok_take(c);
      end
    end
    // End of file: judge an open token, then flag what is missing
    if (last && sticky_st == ST_OK) begin
      if (hdr_in_tok && hdr_phase != PH_RASTER) tok_close(1'b0);
      if (sticky_st == ST_OK) begin
        if (hdr_phase != PH_RASTER) sticky_st = ST_HDR_END;
        else if (bytes_left != 34'd0) sticky_st = ST_SIZE;
      end
    end
    r.done_res   = last;
    r.status     = sticky_st;
    r.img_width  = exp_width;
    r.img_height = exp_height;
    if (last) start_file();
  endtask

  // ---------------------------------------------------------------------------
  // Clock, timeout, output stall and the long hold-off
  // ---------------------------------------------------------------------------

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= hold_on || ($urandom_range(99) < recv_idle_pct);
  end

  // Holds the output off for a fixed count of cycles; the sender keeps
  // offering meanwhile, so the parser fills up and stalls its input
  initial begin
    forever begin
      @(hold_ev);
      hold_on <= 1'b1;
      repeat (HoldCycles) @(posedge clk_i);
      hold_on <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    bad_cnt++;
    if (bad_cnt <= MaxPrints) begin
      $display("mismatch %s: got 0x%0h, want 0x%0h (cycle %0d)", what, got, want,
               cycle_cnt);
    end
  endtask

  always @(posedge clk_i) begin : check_results
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (parse_res_q.size() == 0) begin
        note_mismatch("result with nothing pending", 32'd0, 32'd0);
      end else begin
        want = parse_res_q.pop_front();
        if (pix_valid_o !== want.pix_valid)
          note_mismatch("pix_valid", 32'(pix_valid_o), 32'(want.pix_valid));
        if (pix_byte_o !== want.pix_byte)
          note_mismatch("pix_byte", 32'(pix_byte_o), 32'(want.pix_byte));
        if (done_res_o !== want.done_res)
          note_mismatch("done_res", 32'(done_res_o), 32'(want.done_res));
        if (status_o !== want.status)
          note_mismatch("status", 32'(status_o), 32'(want.status));
        if (img_width_o !== want.img_width)
          note_mismatch("img_width", 32'(img_width_o), 32'(want.img_width));
        if (img_height_o !== want.img_height)
          note_mismatch("img_height", 32'(img_height_o), 32'(want.img_height));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sending
  // ---------------------------------------------------------------------------

  // Offer one byte, wait for the handshake, then predict. Valid stays high
  // on return so back-to-back items need no gap.
  task automatic send_item(input logic [7:0] c, input logic last);
    res_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= c;
    in_last_i  <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (sticky_st == ST_OK) live_items++;
    parse_byte(c, last, r);
    parse_res_q.push_back(r);
  endtask

  task automatic send_file();
    for (int i = 0; i < file_q.size(); i++) send_item(file_q[i], i == file_q.size() - 1);
    file_q.delete();
  endtask

  // ---------------------------------------------------------------------------
  // File builders
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] pick_ws();
    case ($urandom_range(5))
      0:       return 8'h20;
      1:       return 8'h09;
      2:       return 8'h0A;
      3:       return 8'h0D;
      4:       return 8'h0B;
      default: return 8'h0C;
    endcase
  endfunction

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) file_q.push_back(s[i]);
  endtask

  // Whitespace between tokens, sometimes with a comment line after it
  task automatic put_gap();
    logic [7:0] b;
    repeat ($urandom_range(1, 3)) file_q.push_back(pick_ws());
    if ($urandom_range(3) == 0) begin
      file_q.push_back(ChHash);
      repeat ($urandom_range(0, 5)) begin
        b = 8'($urandom_range(255));
        if (b == ChLf) b = ChP;
        file_q.push_back(b);
      end
      file_q.push_back(ChLf);
    end
  endtask

  // Dimension token; v is its value when it is usable for the raster, else 0
  task automatic pick_dim(output string s, output int unsigned v);
    int unsigned pick, d;
    pick = $urandom_range(99);
    v = 0;
    if (pick < 80) begin
      d = $urandom_range(1, 4);
      v = d;
      if ($urandom_range(7) == 0) s = $sformatf("00%0d", d);  // leading zeros
      else s = $sformatf("%0d", d);
    end else if (pick < 85) begin
      v = 65535;
      s = "65535";
    end else if (pick < 89) begin
      s = $sformatf("%0d", $urandom_range(32'h7FFF_FFFF, 32'd65536));
    end else if (pick < 91) begin
      s = "2147483647";
    end else if (pick < 93) begin
      s = "0";
    end else if (pick < 95) begin
      s = "2147483648";  // one past the number limit
    end else if (pick < 97) begin
      s = "+2";
    end else begin
      s = "3x";
    end
  endtask

  // Mostly well-formed files with random content; the rest carries one
  // defect or is plain noise
  task automatic gen_file();
    string       w_txt, h_txt, max_txt, magic_txt;
    int unsigned w_val, h_val, n, pick;
    longint unsigned raster_len;
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(1, 12)) file_q.push_back(8'($urandom_range(255)));
      return;
    end
    pick_dim(w_txt, w_val);
    pick_dim(h_txt, h_val);
    pick = $urandom_range(99);
    if (pick < 86) max_txt = "255";
    else if (pick < 88) max_txt = "000255";
    else if (pick < 91) max_txt = "256";
    else if (pick < 93) max_txt = "0";
    else if (pick < 95) max_txt = "25a";
    else if (pick < 97) max_txt = "-255";
    else max_txt = "99999999999";
    pick = $urandom_range(99);
    if (pick < 95) magic_txt = "P6";
    else if (pick < 96) magic_txt = "P5";
    else if (pick < 97) magic_txt = "P66";
    else if (pick < 98) magic_txt = "p6";
    else magic_txt = "6P";

    if ($urandom_range(3) == 0) put_gap();
    put_str(magic_txt);
    put_gap();
    put_str(w_txt);
    put_gap();
    put_str(h_txt);
    put_gap();
    put_str(max_txt);
    // single separator byte, missing now and then
    if ($urandom_range(99) < 94) file_q.push_back(pick_ws());

    raster_len = longint'(w_val) * longint'(h_val) * 3;
    if (raster_len == 0) begin
      n = $urandom_range(0, 6);
    end else if (raster_len > 36) begin
      n = $urandom_range(0, 12);  // huge image: always cut short
    end else begin
      pick = $urandom_range(99);
      n = int'(raster_len);
      if (pick < 8) n = n + $urandom_range(1, 2);
      else if (pick < 16) n = n - 1;
    end
    repeat (n) file_q.push_back(8'($urandom_range(255)));

    if ($urandom_range(99) < 10) begin
      n = $urandom_range(1, file_q.size());
      while (file_q.size() > n) file_q.delete(file_q.size() - 1);
    end
    if ($urandom_range(99) < 5)
      file_q[$urandom_range(file_q.size() - 1)] = 8'($urandom_range(255));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_directed();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // Smallest good image; raster bytes at both ends of the range
    put_str("P6 1 1 255\n");
    file_q.push_back(8'h00);
    file_q.push_back(8'hFF);
    file_q.push_back(8'h7F);
    send_file();
    // File ends right on the max value token: no separator
    put_str("P6 1 1 255");
    send_file();
    // File ends inside the magic token, which is then judged bad
    put_str("P");
    send_file();
  endtask

  task automatic test_random(input int unsigned s_pct, input int unsigned r_pct,
                             input int unsigned count);
    int unsigned start;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    start = live_items;
    while (live_items - start < count) begin
      gen_file();
      send_file();
    end
  endtask

  task automatic test_hold_off();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    -> hold_ev;
    repeat (3) begin
      gen_file();
      send_file();
    end
  endtask

  initial begin : run_tests
    int unsigned guard;
    start_file();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_random(23, 57, RandItems / 3);
    test_random(57, 23, RandItems / 3);
    test_hold_off();
    test_random(0, 0, RandItems - 2 * (RandItems / 3));

    // Drain: everything accepted must come out before the final check
    in_valid_i <= 1'b0;
    recv_idle_pct = 0;
    guard = 0;
    while (parse_res_q.size() != 0 && guard < 10000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (10) @(posedge clk_i);
    if (parse_res_q.size() != 0)
      note_mismatch("results never delivered", 32'(parse_res_q.size()), 32'd0);

    if (bad_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
